### design/khc_pkg.sv
`default_nettype none

package khc_pkg;

    // Table geometry: the window keeps K_MAX letters at two bits each.
    localparam int K_MAX        = 8;
    localparam int COUNT_WIDTH  = 32;
    localparam int INDEX_WIDTH  = 2 * K_MAX;
    localparam int LEN_WIDTH    = 4;
    localparam int SHIFT_WIDTH  = LEN_WIDTH + 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_WIDTH   = 2;
    localparam int ADDR_WIDTH   = 2;
    localparam int DATA_WIDTH   = 32;

    localparam logic [LEN_WIDTH-1:0] KMER_LEN_RESET = LEN_WIDTH'(K_MAX);

    // Register byte addresses.
    localparam logic [ADDR_WIDTH-1:0] REG_KMER_LENGTH = 2'd0;

    // Transaction modes.
    localparam logic [1:0] MODE_LETTER = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Operations handed from the front end to the counter engine.
    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_INC   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // ASCII letters of the nucleotide alphabet.
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_U_UP = 8'h55;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_T_LO = 8'h74;
    localparam logic [7:0] CH_U_LO = 8'h75;

    typedef struct packed {
        logic                   valid;
        logic [1:0]             code;
    } khc_letter_t;

    typedef struct packed {
        logic [1:0]             op;
        logic [INDEX_WIDTH-1:0] idx;
        logic [COUNT_WIDTH-1:0] total;
    } khc_op_t;

    typedef struct packed {
        logic                   counted;
        logic [INDEX_WIDTH-1:0] counted_index;
        logic [COUNT_WIDTH-1:0] count_value;
        logic [COUNT_WIDTH-1:0] total;
    } khc_result_t;

    typedef struct packed {
        logic                   busy;
        logic                   stage_valid;
        logic [QPTR_WIDTH:0]    out_count;
    } khc_back_status_t;

    function automatic khc_letter_t letter_code(input logic [7:0] s);
        khc_letter_t r;
        r.valid = 1'b1;
        r.code  = 2'd0;
        case (s)
            CH_A_UP, CH_A_LO: r.code = 2'd0;
            CH_C_UP, CH_C_LO: r.code = 2'd1;
            CH_G_UP, CH_G_LO: r.code = 2'd2;
            CH_T_UP, CH_T_LO, CH_U_UP, CH_U_LO: r.code = 2'd3;
            default: r.valid = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### design/khc_front.sv
`default_nettype none

module khc_front
    import khc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_WIDTH-1:0]  paddr,
    input  wire logic [DATA_WIDTH-1:0]  pwdata,
    output logic [DATA_WIDTH-1:0]       prdata,
    output logic                        pready,
    input  wire logic                   push,
    input  wire logic                   stall,
    input  wire logic [1:0]             mode,
    input  wire logic [7:0]             symbol,
    input  wire logic                   seq_start,
    input  wire logic [INDEX_WIDTH-1:0] kmer_index,
    output logic                        q_push,
    output khc_op_t                     q_data
);

    logic [LEN_WIDTH-1:0]   kmer_length_reg;
    logic [INDEX_WIDTH-1:0] window_reg, window_next;
    logic [LEN_WIDTH-1:0]   held_reg, held_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [LEN_WIDTH-1:0]   k_eff;
    logic [INDEX_WIDTH-1:0] kmask;
    logic [INDEX_WIDTH-1:0] win_base, win_shift;
    logic [LEN_WIDTH-1:0]   held_base;
    khc_letter_t            letter;
    logic                   accept;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_KMER_LENGTH)
                  ? DATA_WIDTH'(kmer_length_reg) : '0;
    assign accept = push && !stall;
    assign q_push = accept;

    always_comb
    begin
        if (kmer_length_reg == '0)
            k_eff = LEN_WIDTH'(1);
        else if (kmer_length_reg > LEN_WIDTH'(K_MAX))
            k_eff = LEN_WIDTH'(K_MAX);
        else
            k_eff = kmer_length_reg;
        for (int i = 0; i < INDEX_WIDTH; i++)
        begin
            kmask[i] = (SHIFT_WIDTH'(i) < {k_eff, 1'b0});
        end
    end

    always_comb
    begin
        letter      = letter_code(symbol);
        win_base    = seq_start ? '0 : window_reg;
        held_base   = seq_start ? '0 : held_reg;
        win_shift   = {win_base[INDEX_WIDTH-3:0], letter.code};
        window_next = window_reg;
        held_next   = held_reg;
        total_next  = total_reg;
        q_data.op    = OP_NOP;
        q_data.idx   = '0;
        case (mode)
            MODE_LETTER:
            begin
                if (!letter.valid)
                begin
                    window_next = '0;
                    held_next   = '0;
                end
                else
                begin
                    window_next = win_shift;
                    held_next   = (held_base < LEN_WIDTH'(K_MAX))
                                ? held_base + LEN_WIDTH'(1) : held_base;
                    if (held_next >= k_eff)
                    begin
                        total_next = total_reg + COUNT_WIDTH'(1);
                        q_data.op  = OP_INC;
                        q_data.idx = win_shift & kmask;
                    end
                end
            end
            MODE_READ:
            begin
                q_data.op  = OP_READ;
                q_data.idx = kmer_index & kmask;
            end
            MODE_CLEAR:
            begin
                q_data.op  = OP_CLEAR;
                q_data.idx = kmer_index & kmask;
            end
            default:
            begin
                q_data.op = OP_NOP;
            end
        endcase
        q_data.total = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KMER_LEN_RESET;
            window_reg      <= '0;
            held_reg        <= '0;
            total_reg       <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == REG_KMER_LENGTH)
                kmer_length_reg <= pwdata[LEN_WIDTH-1:0];
            if (accept)
            begin
                window_reg <= window_next;
                held_reg   <= held_next;
                total_reg  <= total_next;
            end
        end
    end

endmodule

`default_nettype wire

### design/khc_op_queue.sv
`default_nettype none

module khc_op_queue
    import khc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire khc_op_t wr_data,
    input  wire logic    rd_en,
    output khc_op_t      rd_data,
    output logic         full,
    output logic         empty
);

    khc_op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wptr_reg, rptr_reg;
    logic [QPTR_WIDTH:0]   count_reg;
    logic                  do_wr, do_rd;

    assign full    = (count_reg == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= wptr_reg + QPTR_WIDTH'(1);
            if (do_rd)
                rptr_reg <= rptr_reg + QPTR_WIDTH'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + (QPTR_WIDTH+1)'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - (QPTR_WIDTH+1)'(1);
        end
    end

endmodule

`default_nettype wire

### design/khc_back.sv
`default_nettype none

module khc_back
    import khc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  wire khc_op_t     q_head,
    output logic             q_pop,
    input  wire logic        pop,
    output khc_result_t      head,
    output logic             empty,
    output khc_back_status_t status
);

    // Counter table with one write and one registered read per cycle.
    logic [COUNT_WIDTH-1:0] mem [1 << INDEX_WIDTH];
    logic [COUNT_WIDTH-1:0] rdata_reg;

    logic                   clearing_reg;
    logic [INDEX_WIDTH-1:0] clr_addr_reg;

    logic                   s1_valid_reg;
    khc_op_t                s1_op_reg;

    logic                   fwd_valid_reg;
    logic [INDEX_WIDTH-1:0] fwd_idx_reg;
    logic [COUNT_WIDTH-1:0] fwd_val_reg;

    khc_result_t            oq_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0]  oq_wptr_reg, oq_rptr_reg;
    logic [QPTR_WIDTH:0]    oq_count_reg;

    logic                   issue;
    logic [COUNT_WIDTH-1:0] base_val, new_val;
    logic                   s1_write;
    logic                   wr_en;
    logic [INDEX_WIDTH-1:0] wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    khc_result_t            s1_result;
    logic                   oq_pop;

    // Issue only with room guaranteed for everything already in flight.
    assign issue = !q_empty && !clearing_reg &&
                   ((oq_count_reg + (QPTR_WIDTH+1)'(s1_valid_reg))
                    < (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign q_pop = issue;

    always_comb
    begin
        base_val = (fwd_valid_reg && fwd_idx_reg == s1_op_reg.idx)
                 ? fwd_val_reg : rdata_reg;
        new_val  = base_val;
        s1_write = 1'b0;
        case (s1_op_reg.op)
            OP_INC:
            begin
                new_val  = base_val + COUNT_WIDTH'(1);
                s1_write = 1'b1;
            end
            OP_CLEAR:
            begin
                new_val  = '0;
                s1_write = 1'b1;
            end
            default:
            begin
                new_val = base_val;
            end
        endcase
        s1_result.counted       = (s1_op_reg.op == OP_INC);
        s1_result.counted_index = s1_result.counted ? s1_op_reg.idx : '0;
        s1_result.count_value   = (s1_op_reg.op == OP_INC || s1_op_reg.op == OP_READ)
                                ? new_val : '0;
        s1_result.total         = s1_op_reg.total;
    end

    assign wr_en   = clearing_reg || (s1_valid_reg && s1_write);
    assign wr_addr = clearing_reg ? clr_addr_reg : s1_op_reg.idx;
    assign wr_data = clearing_reg ? '0 : new_val;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[q_head.idx];
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            s1_op_reg <= q_head;
        fwd_idx_reg <= s1_op_reg.idx;
        fwd_val_reg <= new_val;
        if (s1_valid_reg)
            oq_reg[oq_wptr_reg] <= s1_result;
    end

    assign empty  = (oq_count_reg == '0);
    assign head   = oq_reg[oq_rptr_reg];
    assign oq_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            oq_wptr_reg   <= '0;
            oq_rptr_reg   <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + INDEX_WIDTH'(1);
                if (clr_addr_reg == '1)
                    clearing_reg <= 1'b0;
            end
            s1_valid_reg  <= issue;
            fwd_valid_reg <= s1_valid_reg && s1_write;
            if (s1_valid_reg)
                oq_wptr_reg <= oq_wptr_reg + QPTR_WIDTH'(1);
            if (oq_pop)
                oq_rptr_reg <= oq_rptr_reg + QPTR_WIDTH'(1);
            if (s1_valid_reg && !oq_pop)
                oq_count_reg <= oq_count_reg + (QPTR_WIDTH+1)'(1);
            else if (oq_pop && !s1_valid_reg)
                oq_count_reg <= oq_count_reg - (QPTR_WIDTH+1)'(1);
        end
    end

    assign status.busy        = clearing_reg;
    assign status.stage_valid = s1_valid_reg;
    assign status.out_count   = oq_count_reg;

endmodule

`default_nettype wire

### design/kmer_histogram_counter.sv
// Path: a transaction passes the operation queue, the s1 stage and the output queue.
// Throughput: one transaction per cycle while full is low and results are popped, set by
// the single write and single registered read port of the counter memory with forwarding
// of the previous write. Reset: rst_n is asynchronous and active low; afterwards a clearing
// pass writes zero into all 65536 counters, one per cycle, and full stays high meanwhile.
`default_nettype none

module kmer_histogram_counter
    import khc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_WIDTH-1:0]  paddr,
    input  wire logic [DATA_WIDTH-1:0]  pwdata,
    output logic [DATA_WIDTH-1:0]       prdata,
    output logic                        pready,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             mode,
    input  wire logic [7:0]             symbol,
    input  wire logic                   seq_start,
    input  wire logic [INDEX_WIDTH-1:0] kmer_index,
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        counted,
    output logic [INDEX_WIDTH-1:0]      counted_index,
    output logic [COUNT_WIDTH-1:0]      count_value,
    output logic [COUNT_WIDTH-1:0]      total
);

    // The front end owns the configuration register, the rolling window and the
    // running total. It turns each input transaction into one counter operation.
    logic             q_push, q_full, q_empty, q_pop;
    khc_op_t          q_in, q_head;
    khc_result_t      res_head;
    khc_back_status_t back_status;

    // Input is refused while the operation queue is full or the table is being cleared.
    assign full = q_full || back_status.busy;

    khc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .stall      (full),
        .mode       (mode),
        .symbol     (symbol),
        .seq_start  (seq_start),
        .kmer_index (kmer_index),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    // A short queue decouples the front end from the counter engine.
    khc_op_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_in),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    // The engine reads the counter, updates it in the following cycle with forwarding from
    // the previous write, and places each result into its own output queue.
    khc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .head    (res_head),
        .empty   (empty),
        .status  (back_status)
    );

    assign counted       = res_head.counted;
    assign counted_index = res_head.counted_index;
    assign count_value   = res_head.count_value;
    assign total         = res_head.total;

    // A result entering the output queue must always find room.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.stage_valid |->
            back_status.out_count < (QPTR_WIDTH+1)'(QUEUE_DEPTH))
        else $error("output queue overflow");

    // Nothing moves through the engine while the table is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.busy |-> (!back_status.stage_valid && empty))
        else $error("engine active during clearing pass");

    // A result that counted nothing carries a zero index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !counted) |-> (counted_index == '0))
        else $error("index shown without a counted k-mer");

    // A counted k-mer never shows both a zero count and a zero running total.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && counted && !back_status.busy) |-> (count_value != '0 || total != '0))
        else $error("counted k-mer with no count");

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for the rolling k-mer histogram counter.
//
// Every transaction that the block accepts is also applied to a shadow copy of the
// histogram kept in this module: the rolling window, the count of letters held, the
// table of counters, the running total and the k-mer length register. The shadow copy
// yields the result that the block must return for that transaction. These results
// wait in a queue, and a checker compares every popped result with the oldest one.
//
// The stimulus runs as a series of named tests. Short directed tests come first, and
// longer random phases under several k-mer lengths follow. Both sides of the block
// idle at random. One test holds the result side off long enough to fill the block.
module tb
    import khc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // The package names the three modes in use. The fourth code must leave everything
    // unchanged.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // The clearing pass after reset zeroes 65536 counters. About 400 transactions follow,
    // and each one can wait out a long sender gap and a long receiver stall. The limit
    // allows several times that.
    localparam int CYCLE_LIMIT = 600_000;
    localparam int RANDOM_PHASE_ITEMS = 52;
    localparam int RECENT_DEPTH = 16;

    typedef struct packed {
        logic [1:0]             mode;
        logic [7:0]             symbol;
        logic                   seq_start;
        logic [INDEX_WIDTH-1:0] kmer_index;
    } letter_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_WIDTH-1:0]  paddr;
    logic [DATA_WIDTH-1:0]  pwdata;
    logic [DATA_WIDTH-1:0]  prdata;
    logic                   pready;
    logic                   push;
    logic                   full;
    logic [1:0]             mode;
    logic [7:0]             symbol;
    logic                   seq_start;
    logic [INDEX_WIDTH-1:0] kmer_index;
    logic                   empty;
    logic                   pop;
    logic                   counted;
    logic [INDEX_WIDTH-1:0] counted_index;
    logic [COUNT_WIDTH-1:0] count_value;
    logic [COUNT_WIDTH-1:0] total;

    // This is the shadow copy of the block's state.
    logic [COUNT_WIDTH-1:0] tally [0:(1 << INDEX_WIDTH) - 1];
    logic [INDEX_WIDTH-1:0] window_bits;
    int                     letters_seen;
    logic [COUNT_WIDTH-1:0] grand_total;
    logic [LEN_WIDTH-1:0]   len_reg;

    // This queue holds the results owed by the block, oldest first.
    khc_result_t            pending_updates [$];
    // Indexes that were counted lately. Reads and clears use them so that they hit
    // counters that are not zero.
    logic [INDEX_WIDTH-1:0] recent_kmers [$];

    int                     errors;
    bit                     sender_gaps_on;
    bit                     receiver_stalls_on;
    int                     pop_hold_cycles;

    kmer_histogram_counter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .symbol        (symbol),
        .seq_start     (seq_start),
        .kmer_index    (kmer_index),
        .empty         (empty),
        .pop           (pop),
        .counted       (counted),
        .counted_index (counted_index),
        .count_value   (count_value),
        .total         (total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model of the histogram
    // ------------------------------------------------------------------

    function automatic void reset_histogram_model();
        foreach (tally[i])
        begin
            tally[i] = '0;
        end
        window_bits  = '0;
        letters_seen = 0;
        grand_total  = '0;
        len_reg      = KMER_LEN_RESET;
        recent_kmers.delete();
    endfunction

    // A length of zero counts single letters. Lengths above the window size use the
    // whole window.
    function automatic logic [INDEX_WIDTH-1:0] current_kmer_mask();
        int k;
        k = (len_reg == 0) ? 1 : ((len_reg > K_MAX) ? K_MAX : int'(len_reg));
        return INDEX_WIDTH'((64'd1 << (2 * k)) - 64'd1);
    endfunction

    // This function applies one accepted transaction to the shadow state and returns
    // the result that the block owes for it.
    function automatic khc_result_t apply_to_histogram(letter_item_t item);
        khc_result_t            r;
        logic [INDEX_WIDTH-1:0] kmask;
        logic [INDEX_WIDTH-1:0] slot;
        logic [1:0]             code;
        bit                     is_nucleotide;
        int                     k;
        r     = '0;
        kmask = current_kmer_mask();
        k     = (len_reg == 0) ? 1 : ((len_reg > K_MAX) ? K_MAX : int'(len_reg));
        case (item.mode)
            MODE_LETTER:
            begin
                if (item.seq_start)
                begin
                    window_bits  = '0;
                    letters_seen = 0;
                end
                is_nucleotide = 1'b1;
                code = 2'd0;
                case (item.symbol)
                    CH_A_UP, CH_A_LO: code = 2'd0;
                    CH_C_UP, CH_C_LO: code = 2'd1;
                    CH_G_UP, CH_G_LO: code = 2'd2;
                    CH_T_UP, CH_T_LO, CH_U_UP, CH_U_LO: code = 2'd3;
                    default: is_nucleotide = 1'b0;
                endcase
                if (!is_nucleotide)
                begin
                    // Any other letter empties the window, so no k-mer spans it.
                    window_bits  = '0;
                    letters_seen = 0;
                end
                else
                begin
                    window_bits = {window_bits[INDEX_WIDTH-3:0], code};
                    if (letters_seen < K_MAX)
                    begin
                        letters_seen++;
                    end
                    if (letters_seen >= k)
                    begin
                        slot = window_bits & kmask;
                        tally[slot] = tally[slot] + 1'b1;
                        grand_total = grand_total + 1'b1;
                        r.counted       = 1'b1;
                        r.counted_index = slot;
                        r.count_value   = tally[slot];
                        recent_kmers.push_back(slot);
                        if (recent_kmers.size() > RECENT_DEPTH)
                        begin
                            void'(recent_kmers.pop_front());
                        end
                    end
                end
            end
            MODE_READ:
            begin
                slot = item.kmer_index & kmask;
                r.count_value = tally[slot];
            end
            MODE_CLEAR:
            begin
                slot = item.kmer_index & kmask;
                tally[slot] = '0;
            end
            default:
            begin
                // The unused mode changes nothing and only reports the total.
            end
        endcase
        r.total = grand_total;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Most gaps are short, and now and then one is long.
    function automatic int idle_length(bit enabled);
        int roll;
        if (!enabled)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic letter_item_t make_item(logic [1:0] m, logic [7:0] s, logic start,
                                               logic [INDEX_WIDTH-1:0] idx);
        letter_item_t item;
        item.mode       = m;
        item.symbol     = s;
        item.seq_start  = start;
        item.kmer_index = idx;
        return item;
    endfunction

    function automatic logic [7:0] nucleotide_letter(int n);
        case (n)
            0: return CH_A_UP;
            1: return CH_C_UP;
            2: return CH_G_UP;
            3: return CH_T_UP;
            4: return CH_U_UP;
            5: return CH_A_LO;
            6: return CH_C_LO;
            7: return CH_G_LO;
            8: return CH_T_LO;
            default: return CH_U_LO;
        endcase
    endfunction

    // Most random transactions are nucleotide letters, so that long runs of valid
    // k-mers build up. The rest are stray bytes, reads, clears and the unused mode.
    // The fields that a mode ignores carry random values.
    function automatic letter_item_t random_item();
        letter_item_t item;
        int           roll;
        item.mode       = MODE_LETTER;
        item.symbol     = 8'($urandom);
        item.seq_start  = ($urandom_range(0, 19) == 0);
        item.kmer_index = INDEX_WIDTH'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 74)
        begin
            item.symbol = nucleotide_letter($urandom_range(0, 9));
        end
        else if (roll < 97 && roll >= 82)
        begin
            item.mode = (roll < 91) ? MODE_READ : MODE_CLEAR;
            // Aim at a counter that was counted lately. The bits above the k-mer
            // are junk that the block must mask off.
            if (recent_kmers.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                item.kmer_index = recent_kmers[$urandom_range(0, recent_kmers.size() - 1)]
                                  | (INDEX_WIDTH'($urandom) & ~current_kmer_mask());
            end
        end
        else if (roll >= 97)
        begin
            item.mode = MODE_UNUSED;
        end
        return item;
    endfunction

    // Each task below starts and ends at a falling edge. The sender leaves push high
    // after a transaction, so that back-to-back transactions need no dip in push.
    task automatic send_item(input letter_item_t item);
        int gap;
        gap = idle_length(sender_gaps_on);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode       = item.mode;
        symbol     = item.symbol;
        seq_start  = item.seq_start;
        kmer_index = item.kmer_index;
        push       = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (full);
        pending_updates.push_back(apply_to_histogram(item));
        @(negedge clk);
    endtask

    // The sender pauses until every owed result has been popped.
    task automatic drain_updates();
        push = 1'b0;
        while (pending_updates.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // This task writes the k-mer length register and reads it back. It is called only
    // with nothing in flight. The upper data bits are junk that the register must drop.
    task automatic set_kmer_length(input logic [LEN_WIDTH-1:0] len);
        logic [DATA_WIDTH-1:0] readback;
        drain_updates();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_KMER_LENGTH;
        pwdata  = DATA_WIDTH'($urandom);
        pwdata[LEN_WIDTH-1:0] = len;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        len_reg = len;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback[LEN_WIDTH-1:0] !== len)
        begin
            $display("%0t: mismatch in kmer_length readback: expected %h, got %h",
                     $time, len, readback[LEN_WIDTH-1:0]);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver drives pop at falling edges. A hold request from a test stops it
    // for the number of cycles asked. It counts these cycles itself.
    initial
    begin : receiver
        int stall;
        stall = 0;
        pop   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pop_hold_cycles > 0)
            begin
                pop = 1'b0;
                repeat (pop_hold_cycles) @(negedge clk);
                pop_hold_cycles = 0;
            end
            if (stall > 0)
            begin
                pop = 1'b0;
                stall--;
            end
            else
            begin
                pop   = 1'b1;
                stall = idle_length(receiver_stalls_on);
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: mismatch in %s: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Every popped result must match the oldest result still owed.
    always @(posedge clk)
    begin : result_checker
        khc_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_updates.size() == 0)
            begin
                $display("%0t: result transaction with nothing owed: %b %h %h %h",
                         $time, counted, counted_index, count_value, total);
                errors++;
            end
            else
            begin
                want = pending_updates.pop_front();
                compare_field("counted", 32'(want.counted), 32'(counted));
                compare_field("counted_index", 32'(want.counted_index), 32'(counted_index));
                compare_field("count_value", want.count_value, count_value);
                compare_field("total", want.total, total);
            end
        end
    end

    // The watchdog ends a run that hangs.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run exceeded its cycle limit", $time);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After clearing, the first and last counters and the total must read zero. The unused
    // mode and a stray byte must change nothing. The first transaction waits for the
    // clearing pass to end.
    task automatic test_cleared_table();
        send_item(make_item(MODE_READ, 8'h00, 1'b0, '0));
        send_item(make_item(MODE_READ, 8'hFF, 1'b1, '1));
        send_item(make_item(MODE_UNUSED, CH_A_UP, 1'b1, 16'h1234));
        send_item(make_item(MODE_LETTER, 8'h4E, 1'b0, '1));
        drain_updates();
    endtask

    // Every value of the register, zero and the values past the window size among
    // them, is written and read back.
    task automatic test_length_register();
        for (int v = 0; v < (1 << LEN_WIDTH); v++)
        begin
            set_kmer_length(LEN_WIDTH'(v));
        end
    endtask

    // This test sends letters of both cases, the U alias, stray bytes, sequence starts,
    // reads and clears with junk in the high index bits, and a length change in the
    // middle of a sequence.
    task automatic test_directed_letters();
        set_kmer_length(LEN_WIDTH'(2));
        send_item(make_item(MODE_LETTER, CH_A_UP, 1'b1, '1));
        send_item(make_item(MODE_LETTER, CH_C_LO, 1'b0, '0));
        send_item(make_item(MODE_LETTER, CH_G_UP, 1'b0, '0));
        send_item(make_item(MODE_LETTER, CH_T_LO, 1'b0, '0));
        send_item(make_item(MODE_LETTER, CH_U_UP, 1'b0, '0));
        send_item(make_item(MODE_LETTER, CH_U_LO, 1'b0, '0));
        send_item(make_item(MODE_LETTER, CH_A_LO, 1'b0, '0));
        send_item(make_item(MODE_LETTER, CH_G_LO, 1'b0, '0));
        // A stray byte empties the window, and so does a sequence start.
        send_item(make_item(MODE_LETTER, 8'h4E, 1'b0, '0));
        send_item(make_item(MODE_LETTER, CH_T_UP, 1'b0, '0));
        send_item(make_item(MODE_LETTER, 8'h00, 1'b0, '0));
        send_item(make_item(MODE_LETTER, CH_C_UP, 1'b1, '0));
        send_item(make_item(MODE_LETTER, CH_C_UP, 1'b0, '0));
        send_item(make_item(MODE_LETTER, 8'hFF, 1'b1, '0));
        // The first read and the clear carry junk above the k-mer bits.
        send_item(make_item(MODE_READ, 8'hFF, 1'b1, 16'hFFF5));
        send_item(make_item(MODE_READ, 8'h00, 1'b0, 16'h000F));
        send_item(make_item(MODE_CLEAR, CH_A_UP, 1'b1, 16'hAB0F));
        send_item(make_item(MODE_READ, 8'h00, 1'b0, 16'h000F));
        send_item(make_item(MODE_LETTER, CH_G_UP, 1'b1, '0));
        send_item(make_item(MODE_LETTER, CH_A_UP, 1'b0, '0));
        // The window survives length changes. Zero acts as one. The largest value
        // acts as the window size, so this short sequence stops counting.
        set_kmer_length('0);
        send_item(make_item(MODE_LETTER, CH_T_UP, 1'b0, '0));
        set_kmer_length('1);
        send_item(make_item(MODE_LETTER, CH_A_LO, 1'b0, '0));
        send_item(make_item(MODE_UNUSED, 8'h55, 1'b1, '1));
        drain_updates();
    endtask

    // The random phases run under several lengths, the extremes among them. The idle
    // pattern is chosen again at each phase start and every 20 transactions after it, and
    // some stretches run without any idling.
    task automatic test_random_sequences();
        int lengths [6];
        lengths = '{8, 1, 0, 15, 3, 0};
        lengths[5] = $urandom_range(1, K_MAX);
        foreach (lengths[p])
        begin
            set_kmer_length(LEN_WIDTH'(lengths[p]));
            for (int n = 0; n < RANDOM_PHASE_ITEMS; n++)
            begin
                if (n % 20 == 0)
                begin
                    sender_gaps_on     = ($urandom_range(0, 3) != 0);
                    receiver_stalls_on = ($urandom_range(0, 3) != 0);
                end
                send_item(random_item());
            end
        end
        drain_updates();
    endtask

    // The receiver holds off for a long stretch while the sender keeps pushing, so the
    // block fills and raises full. Once every result has come, 20 more go with gaps.
    task automatic test_backpressure();
        set_kmer_length(LEN_WIDTH'($urandom_range(1, K_MAX)));
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b1;
        pop_hold_cycles    = 200;
        for (int n = 0; n < 40; n++)
        begin
            send_item(random_item());
        end
        drain_updates();
        sender_gaps_on = 1'b1;
        for (int n = 0; n < 20; n++)
        begin
            send_item(random_item());
        end
        drain_updates();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        errors             = 0;
        pop_hold_cycles    = 0;
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        push       = 1'b0;
        mode       = MODE_LETTER;
        symbol     = '0;
        seq_start  = 1'b0;
        kmer_index = '0;
        reset_histogram_model();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_cleared_table();
        test_length_register();
        test_directed_letters();
        test_random_sequences();
        test_backpressure();

        // Every result has been popped. A wait after that lets a stray extra result show up.
        drain_updates();
        repeat (10) @(negedge clk);
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
